>>> sv/assert_macros.svh
// assertion macros used by the top level of the page allocator
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FPSA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FPSA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/fpsa_pkg.sv
// package of the free page stack allocator: codes, states, shared types
// no dependencies
package fpsa_pkg;

    localparam int STACK_DEPTH_DEF = 16384;
    localparam int PAGE_BYTES_DEF  = 4096;

    localparam int ADDR_W   = 64;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int FCOUNT_W = 15;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OOM      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BELOW    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECT_MAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERN_END   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KPS,
        ST_KPE_SUB,
        ST_KPE_ADD,
        ST_PSTART,
        ST_PEND,
        ST_WALK,
        ST_ALLOC,
        ST_FREE
    } state_t;

    // request to the shared adder
    typedef struct packed {
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic              sub;
    } alu_req_t;

endpackage

>>> sv/free_page_stack_allocator.sv
// top level of the free page stack allocator: sequencer, registers, result port
// depends on fpsa_pkg, fpsa_alu, fpsa_stack_mem and assert_macros.svh
//
//  channel   handshake              payload
//  --------  ---------------------  ----------------------------------------------
//  command   start && !busy         command, region_base, region_length,
//                                   region_usable, free_address
//  result    done (one cycle)       page_address, status, free_count
//  config    cfg_write              cfg_index, cfg_data
//
// clear, an empty allocate, a free into a full stack, or an unusable or short
// region: result in the cycle after the transfer, busy stays low
// allocate and free: one state, at most one stack access and one pass through the adder
// add region: five setup steps on the shared adder, then one page pushed per cycle;
// a last walk step closes the walk, then the result; a run of pages under the kernel
// image is skipped in one extra walk step; a full stack ends the walk with overflow
// reset is asynchronous, active low, and leaves the stack empty; no clearing pass
// the result strobe cannot be held off; it is a one-cycle pulse
`include "assert_macros.svh"

module free_page_stack_allocator
    import fpsa_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int PAGE_BYTES  = PAGE_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command transfer
    input  logic                 start,
    output logic                 busy,
    input  logic [CMD_W-1:0]     command,
    input  logic [ADDR_W-1:0]    region_base,
    input  logic [ADDR_W-1:0]    region_length,
    input  logic                 region_usable,
    input  logic [ADDR_W-1:0]    free_address,
    // result transfer
    output logic                 done,
    output logic [ADDR_W-1:0]    page_address,
    output logic [STATUS_W-1:0]  status,
    output logic [FCOUNT_W-1:0]  free_count,
    // configuration writes
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0]     DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [ADDR_W-1:0] PG      = ADDR_W'(PAGE_BYTES);
    localparam logic [ADDR_W-1:0] PG_M1   = PG - ADDR_W'(1);
    localparam logic [ADDR_W-1:0] PG_MASK = ~PG_M1;

    // configuration registers
    logic [ADDR_W-1:0] dmo_reg, kvs_reg, kve_reg;

    // sequencer and stack pointer
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    // operands held over the item
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] kps_reg, kps_next;
    logic [ADDR_W-1:0] kpe_reg, kpe_next;
    logic [ADDR_W-1:0] p_reg, p_next;
    logic [ADDR_W-1:0] end_reg, end_next;

    // result registers
    logic                done_reg;
    logic [ADDR_W-1:0]   page_address_reg;
    logic [STATUS_W-1:0] status_reg;

    // control from the output block
    logic                res_load;
    logic [ADDR_W-1:0]   res_addr;
    logic [STATUS_W-1:0] res_status;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_rdata;
    logic [AW-1:0]       mem_raddr;

    alu_req_t          alu_req;
    logic [ADDR_W-1:0] alu_sum;
    logic              alu_carry;

    // shared conditions
    logic stack_full, stack_empty, region_skip, p_lt_end, p_overlap;

    assign stack_full  = (count_reg >= DEPTH_C);
    assign stack_empty = (count_reg == '0);
    // unusable or shorter than one page adds nothing
    assign region_skip = !region_usable || (region_length < PG);
    assign p_lt_end    = (p_reg < end_reg);
    // page overlaps the kernel range; the adder holds p + page, wrapping
    assign p_overlap   = (p_reg < kpe_reg) && (alu_sum > kps_reg);

    // read address always tracks the top of stack
    assign mem_raddr = count_reg[AW-1:0] - AW'(1);

    fpsa_alu u_alu (
        .req   (alu_req),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    fpsa_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // configuration writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmo_reg <= '0;
            kvs_reg <= '0;
            kve_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_DIRECT_MAP: dmo_reg <= cfg_data;
                CFG_KERN_START: kvs_reg <= cfg_data;
                CFG_KERN_END:   kve_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_CLEAR: state_next = ST_IDLE;
                        CMD_ADD:   state_next = region_skip ? ST_IDLE : ST_KPS;
                        CMD_ALLOC: state_next = stack_empty ? ST_IDLE : ST_ALLOC;
                        CMD_FREE:  state_next = stack_full ? ST_IDLE : ST_FREE;
                    endcase
                end
            end
            ST_KPS:     state_next = ST_KPE_SUB;
            ST_KPE_SUB: state_next = ST_KPE_ADD;
            ST_KPE_ADD: state_next = ST_PSTART;
            ST_PSTART:  state_next = ST_PEND;
            ST_PEND:    state_next = ST_WALK;
            ST_WALK:
            begin
                priority if (!p_lt_end)
                    state_next = ST_IDLE;
                else if (p_overlap)
                    state_next = ST_WALK;
                else if (stack_full)
                    state_next = ST_IDLE;
                else
                    state_next = ST_WALK;
            end
            ST_ALLOC:   state_next = ST_IDLE;
            ST_FREE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath control
    always_comb
    begin
        count_next = count_reg;
        base_next  = base_reg;
        len_next   = len_reg;
        kps_next   = kps_reg;
        kpe_next   = kpe_reg;
        p_next     = p_reg;
        end_next   = end_reg;
        res_load   = 1'b0;
        res_addr   = '0;
        res_status = STAT_OK;
        mem_we     = 1'b0;
        mem_wdata  = p_reg;
        alu_req.a   = p_reg;
        alu_req.b   = PG;
        alu_req.sub = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // region base and free address share one holding register
                base_next = (command == CMD_FREE) ? free_address : region_base;
                len_next  = region_length;
                if (start)
                begin
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            res_load   = 1'b1;
                        end
                        CMD_ADD:
                        begin
                            res_load = region_skip;
                        end
                        CMD_ALLOC:
                        begin
                            if (stack_empty)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_OOM;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        CMD_FREE:
                        begin
                            if (stack_full)
                            begin
                                res_load   = 1'b1;
                                res_status = STAT_OVERFLOW;
                            end
                        end
                    endcase
                end
            end
            ST_KPS:
            begin
                alu_req.a   = kvs_reg;
                alu_req.b   = dmo_reg;
                alu_req.sub = 1'b1;
                kps_next    = alu_sum & PG_MASK;
            end
            ST_KPE_SUB:
            begin
                alu_req.a   = kve_reg;
                alu_req.b   = dmo_reg;
                alu_req.sub = 1'b1;
                kpe_next    = alu_sum;
            end
            ST_KPE_ADD:
            begin
                // round the kernel end up to a page
                alu_req.a = kpe_reg;
                alu_req.b = PG_M1;
                kpe_next  = alu_sum & PG_MASK;
            end
            ST_PSTART:
            begin
                alu_req.a = base_reg;
                alu_req.b = PG_M1;
                p_next    = alu_sum & PG_MASK;
            end
            ST_PEND:
            begin
                alu_req.a = base_reg;
                alu_req.b = len_reg;
                end_next  = alu_sum & PG_MASK;
            end
            ST_WALK:
            begin
                // adder holds p + page for the overlap test and the step
                priority if (!p_lt_end)
                begin
                    res_load = 1'b1;
                end
                else if (p_overlap)
                begin
                    // skip every page up to the kernel end at once
                    p_next = kpe_reg;
                end
                else if (stack_full)
                begin
                    // rest of the region is dropped
                    res_load   = 1'b1;
                    res_status = STAT_OVERFLOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                    p_next     = alu_sum;
                end
            end
            ST_ALLOC:
            begin
                alu_req.a = mem_rdata;
                alu_req.b = dmo_reg;
                res_load  = 1'b1;
                res_addr  = alu_sum;
            end
            ST_FREE:
            begin
                alu_req.a   = base_reg;
                alu_req.b   = dmo_reg;
                alu_req.sub = 1'b1;
                res_load    = 1'b1;
                mem_wdata   = alu_sum;
                if (!alu_carry)
                begin
                    // address lies below the direct map
                    res_status = STAT_BELOW;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= res_load;
        end
    end

    // operand and result payload
    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        len_reg  <= len_next;
        kps_reg  <= kps_next;
        kpe_reg  <= kpe_next;
        p_reg    <= p_next;
        end_reg  <= end_next;
        if (res_load)
        begin
            page_address_reg <= res_addr;
            status_reg       <= res_status;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign page_address = page_address_reg;
    assign status       = status_reg;
    // count only changes on a later transfer, so it is steady under the strobe
    assign free_count   = FCOUNT_W'(count_reg);

    `FPSA_ASSERT(a_count_in_range, count_reg <= DEPTH_C, "stack count past depth")
    `FPSA_ASSERT(a_no_push_when_full, mem_we |-> !stack_full, "push into a full stack")
    `FPSA_ASSERT(a_done_in_idle, done_reg |-> (state_reg == ST_IDLE), "result while still busy")
    `FPSA_ASSERT(a_empty_alloc_oom,
        (start && !busy && command == CMD_ALLOC && stack_empty)
            |=> (done_reg && status_reg == STAT_OOM),
        "empty allocate did not report out of memory")

endmodule

>>> sv/fpsa_alu.sv
// shared 64-bit add / subtract unit of the page allocator
// depends on fpsa_pkg
module fpsa_alu
    import fpsa_pkg::*;
(
    input  alu_req_t          req,
    output logic [ADDR_W-1:0] sum,
    output logic              carry
);

    logic [ADDR_W:0] full_sum;

    // subtract as a + ~b + 1; carry set means no borrow
    assign full_sum = {1'b0, req.a} + {1'b0, req.b ^ {ADDR_W{req.sub}}}
                      + {{ADDR_W{1'b0}}, req.sub};
    assign sum   = full_sum[ADDR_W-1:0];
    assign carry = full_sum[ADDR_W];

endmodule

>>> sv/fpsa_stack_mem.sv
// page stack storage: one write port, one read port with registered data
// depends on fpsa_pkg
module fpsa_stack_mem
    import fpsa_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [ADDR_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [ADDR_W-1:0] rdata
);

    logic [ADDR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
